FILE: rtl/mapg_pkg.sv
package mapg_pkg;

  // Field widths of the transactions and configuration registers
  localparam int unsigned AddrOutW  = 40;
  localparam int unsigned WsMbW     = 21;
  localparam int unsigned StrideW   = 40;
  localparam int unsigned PctW      = 7;
  localparam int unsigned LcgW      = 64;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  // Generator and addressing constants
  localparam logic [LcgW-1:0]     LcgMul     = 64'd6364136223846793005;
  localparam logic [WsMbW-1:0]    MaxWsMb    = 21'd1048576;
  localparam int unsigned         MbShift    = 20;
  localparam int unsigned         LineBits   = 6;
  localparam logic [StrideW-1:0]  LineBytes  = 40'd64;
  localparam logic [PctW-1:0]     PctFull    = 7'd100;
  localparam logic [WsMbW-1:0]    PctDivisor = 21'd100;

  // Iterative divider: radix 16, four restoring steps per cycle;
  // counter start value is the last step index of each pass
  localparam int unsigned DivStepBits = 4;
  localparam int unsigned CntW        = 4;
  localparam logic [CntW-1:0] WsLastCnt  = CntW'((LcgW - MbShift) / DivStepBits - 1);
  localparam logic [CntW-1:0] PctLastCnt = CntW'(LcgW / DivStepBits - 1);

  // Multiplier step schedule (64x64 low half from three 32x32 products)
  localparam logic [CntW-1:0] MulStepLoLo = 4'd0;
  localparam logic [CntW-1:0] MulStepHiLo = 4'd1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPatternMode  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWorkingSetMb = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStrideBytes  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWritePercent = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSeedInit     = 3'd4;

  // Sequencer states
  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StSeq  = 5'b00100,
    StDiv  = 5'b01000,
    StDone = 5'b10000
  } state_e;

endpackage

FILE: rtl/memory_access_pattern_generator_core.sv
// Steps after accept: sequential mode computes the next index directly; random mode
//   steps the generator on the shared 32x32 multiplier, then does the working-set
//   modulo (when the size is nonzero); both then run the percent modulo when the
//   write percent is strictly between 0 and 100, each on the radix-16 divider loop.
// Flow: one transaction at a time, the next accepted once the last is registered.
// Reset: configuration returns to its defaults, generator state and index clear.
module memory_access_pattern_generator_core #(
  parameter int unsigned ADDR_WIDTH = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [mapg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mapg_pkg::CfgDataW-1:0]   cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            restart_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mapg_pkg::AddrOutW-1:0]   address_o,
  output logic                            is_write_o
);

  localparam int unsigned LcgW  = mapg_pkg::LcgW;
  localparam int unsigned WsMbW = mapg_pkg::WsMbW;
  localparam int unsigned IdxW  = mapg_pkg::AddrOutW;
  localparam int unsigned RemW  = WsMbW + 1;

  // Configuration registers
  logic                             pattern_mode_q;
  logic [WsMbW-1:0]                 working_set_mb_q;
  logic [mapg_pkg::StrideW-1:0]     stride_bytes_q;
  logic [mapg_pkg::PctW-1:0]        write_percent_q;
  logic [LcgW-1:0]                  seed_init_q;

  // Control state
  mapg_pkg::state_e                 state_q, state_d;
  logic [mapg_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                             out_valid_q, out_valid_d;
  logic [LcgW-1:0]                  lcg_q, lcg_d;
  logic [ADDR_WIDTH-1:0]            run_index_q, run_index_d;

  // Datapath registers
  logic [LcgW-1:0]                  acc_q, acc_d;
  logic [LcgW-1:0]                  dvd_q, dvd_d;
  logic [WsMbW-1:0]                 rem_q, rem_d;
  logic [WsMbW-1:0]                 dvs_q, dvs_d;
  logic                             div_pct_q, div_pct_d;
  logic [IdxW-1:0]                  idx_q, idx_d;
  logic                             wr_q, wr_d;
  logic [mapg_pkg::AddrOutW-1:0]    address_q;
  logic                             is_write_q;

  // Combinational helpers
  logic [WsMbW-1:0]                 mb_sat;
  logic [mapg_pkg::PctW-1:0]        pct_sat;
  logic                             pct_mid;
  logic [31:0]                      mul_a, mul_b;
  logic [LcgW-1:0]                  mul_p;
  logic [LcgW-1:0]                  lcg_new;
  logic [RemW-1:0]                  div_r;
  logic [LcgW-1:0]                  div_d;
  logic [WsMbW-1:0]                 rem_nx;
  logic [IdxW:0]                    seq_sum;
  logic [IdxW:0]                    wbytes;
  logic [IdxW-1:0]                  seq_idx;
  logic [IdxW-1:0]                  ws_idx;
  logic [mapg_pkg::StrideW-1:0]     stride_eff;
  logic                             fin;
  logic [IdxW-1:0]                  fin_idx;
  logic [LcgW-1:0]                  fin_lcg;
  logic                             out_free;
  logic [LcgW-1:0]                  idx_ext;
  logic [LcgW-1:0]                  run_ext;

  // Saturated settings
  assign mb_sat  = (working_set_mb_q > mapg_pkg::MaxWsMb) ? mapg_pkg::MaxWsMb
                                                            : working_set_mb_q;
  assign pct_sat = (write_percent_q > mapg_pkg::PctFull) ? mapg_pkg::PctFull
                                                           : write_percent_q;
  assign pct_mid = (pct_sat != '0) && (pct_sat != mapg_pkg::PctFull);

  // Shared 32x32 multiplier, operands picked by the step counter
  always_comb begin
    mul_a = (cnt_q == mapg_pkg::MulStepHiLo) ? lcg_q[63:32] : lcg_q[31:0];
    mul_b = (cnt_q == mapg_pkg::MulStepLoLo || cnt_q == mapg_pkg::MulStepHiLo)
            ? mapg_pkg::LcgMul[31:0] : mapg_pkg::LcgMul[63:32];
    mul_p = LcgW'(mul_a) * LcgW'(mul_b);
  end
  assign lcg_new = {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};

  // Radix-16 restoring divider step
  always_comb begin
    div_r = RemW'(rem_q);
    div_d = dvd_q;
    for (int i = 0; i < mapg_pkg::DivStepBits; i++) begin
      div_r = {div_r[RemW-2:0], div_d[LcgW-1]};
      div_d = {div_d[LcgW-2:0], 1'b0};
      if (div_r >= RemW'(dvs_q)) begin
        div_r = div_r - RemW'(dvs_q);
      end
    end
    rem_nx = div_r[WsMbW-1:0];
  end

  // Sequential address step and random address assembly
  assign run_ext    = LcgW'(run_index_q);
  assign stride_eff = (stride_bytes_q == '0) ? mapg_pkg::LineBytes : stride_bytes_q;
  assign seq_sum    = (IdxW+1)'(run_ext[IdxW-1:0]) + (IdxW+1)'(stride_eff);
  assign wbytes     = {mb_sat, {mapg_pkg::MbShift{1'b0}}};
  assign seq_idx    = (seq_sum >= wbytes) ? '0
                    : {seq_sum[IdxW-1:mapg_pkg::LineBits], {mapg_pkg::LineBits{1'b0}}};
  assign ws_idx     = {rem_nx[mapg_pkg::MbShift-1:0],
                       lcg_q[mapg_pkg::MbShift-1:mapg_pkg::LineBits],
                       {mapg_pkg::LineBits{1'b0}}};

  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_ext  = LcgW'(idx_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lcg_d       = lcg_q;
    run_index_d = run_index_q;
    acc_d       = acc_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    div_pct_d   = div_pct_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    fin         = 1'b0;
    fin_idx     = idx_q;
    fin_lcg     = lcg_q;

    unique case (state_q)
      mapg_pkg::StIdle: begin
        if (in_valid_i) begin
          if (restart_i) begin
            lcg_d       = seed_init_q;
            run_index_d = '0;
          end
          cnt_d   = '0;
          state_d = pattern_mode_q ? mapg_pkg::StMul : mapg_pkg::StSeq;
        end
      end
      mapg_pkg::StMul: begin
        if (cnt_q == mapg_pkg::MulStepLoLo) begin
          acc_d = mul_p + LcgW'(1);
          cnt_d = cnt_q + 1'b1;
        end else if (cnt_q == mapg_pkg::MulStepHiLo) begin
          acc_d[63:32] = acc_q[63:32] + mul_p[31:0];
          cnt_d        = cnt_q + 1'b1;
        end else begin
          lcg_d = lcg_new;
          if (mb_sat == '0) begin
            fin     = 1'b1;
            fin_idx = '0;
            fin_lcg = lcg_new;
          end else begin
            dvd_d     = {lcg_new[LcgW-1:mapg_pkg::MbShift], {mapg_pkg::MbShift{1'b0}}};
            rem_d     = '0;
            dvs_d     = mb_sat;
            cnt_d     = mapg_pkg::WsLastCnt;
            div_pct_d = 1'b0;
            state_d   = mapg_pkg::StDiv;
          end
        end
      end
      mapg_pkg::StSeq: begin
        fin     = 1'b1;
        fin_idx = seq_idx;
      end
      mapg_pkg::StDiv: begin
        dvd_d = div_d;
        rem_d = rem_nx;
        if (cnt_q == '0) begin
          if (div_pct_q) begin
            wr_d    = (rem_nx < WsMbW'(pct_sat));
            state_d = mapg_pkg::StDone;
          end else begin
            fin     = 1'b1;
            fin_idx = ws_idx;
          end
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      mapg_pkg::StDone: begin
        if (out_free) begin
          run_index_d = idx_ext[ADDR_WIDTH-1:0];
          state_d     = mapg_pkg::StIdle;
        end
      end
      default: begin
        state_d = mapg_pkg::StIdle;
      end
    endcase

    // Address known: run the percent modulo or finish directly
    if (fin) begin
      idx_d = fin_idx;
      if (pct_mid) begin
        dvd_d     = fin_lcg;
        rem_d     = '0;
        dvs_d     = mapg_pkg::PctDivisor;
        cnt_d     = mapg_pkg::PctLastCnt;
        div_pct_d = 1'b1;
        state_d   = mapg_pkg::StDiv;
      end else begin
        wr_d    = (pct_sat == mapg_pkg::PctFull);
        state_d = mapg_pkg::StDone;
      end
    end
  end

  // Output slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == mapg_pkg::StDone && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mapg_pkg::StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      lcg_q       <= '0;
      run_index_q <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      lcg_q       <= lcg_d;
      run_index_q <= run_index_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_mode_q   <= 1'b1;
      working_set_mb_q <= 21'd256;
      stride_bytes_q   <= 40'd4096;
      write_percent_q  <= 7'd50;
      seed_init_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mapg_pkg::CfgPatternMode:  pattern_mode_q   <= cfg_data_i[0];
        mapg_pkg::CfgWorkingSetMb: working_set_mb_q <= cfg_data_i[WsMbW-1:0];
        mapg_pkg::CfgStrideBytes:  stride_bytes_q   <= cfg_data_i[mapg_pkg::StrideW-1:0];
        mapg_pkg::CfgWritePercent: write_percent_q  <= cfg_data_i[mapg_pkg::PctW-1:0];
        mapg_pkg::CfgSeedInit:     seed_init_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    dvs_q     <= dvs_d;
    div_pct_q <= div_pct_d;
    idx_q     <= idx_d;
    wr_q      <= wr_d;
    if (state_q == mapg_pkg::StDone && out_free) begin
      address_q  <= mapg_pkg::AddrOutW'(LcgW'(run_index_d));
      is_write_q <= wr_q;
    end
  end

  assign in_stall_o  = (state_q != mapg_pkg::StIdle);
  assign out_valid_o = out_valid_q;
  assign address_o   = address_q;
  assign is_write_o  = is_write_q;

endmodule

FILE: sim/tb_memory_access_pattern_generator_core.sv
`timescale 1ns / 1ps

module tb_memory_access_pattern_generator_core;

  localparam int unsigned AddrW         = 40;
  localparam logic [63:0] LcgMult       = 64'd6364136223846793005;
  localparam logic [63:0] MaxRegionMb   = 64'd1048576;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned NumPhases     = 12;
  localparam int unsigned ItemsPerPhase = 100;

  typedef struct packed {
    logic [0:0]                   mode;
    logic [mapg_pkg::WsMbW-1:0]   ws_mb;
    logic [mapg_pkg::StrideW-1:0] stride;
    logic [mapg_pkg::PctW-1:0]    pct;
    logic [mapg_pkg::LcgW-1:0]    seed;
  } gen_cfg_t;

  typedef struct packed {
    logic [mapg_pkg::AddrOutW-1:0] addr;
    logic                          wr;
  } access_t;

  typedef struct packed {
    gen_cfg_t cfg;
    logic     restart;
    logic     has_exp;
    access_t  exp;
  } dir_row_t;

  localparam gen_cfg_t ResetCfg = '{1'b1, 21'd256, 40'd4096, 7'd50, 64'd0};

  // Directed rows: config to hold, restart flag, and typed expectation where obvious
  localparam int unsigned NumDirected = 21;
  localparam dir_row_t DirRows [NumDirected] = '{
    // defaults after reset: generator steps from 0 to 1
    '{'{1'b1, 21'd256, 40'd4096, 7'd50, 64'd0}, 1'b0, 1'b1, '{40'h0, 1'b1}},
    '{'{1'b1, 21'd256, 40'd4096, 7'd50, 64'd0}, 1'b1, 1'b1, '{40'h0, 1'b1}},
    // sequential, zero stride acts as one line, never write
    '{'{1'b0, 21'd1, 40'd0, 7'd0, 64'd0}, 1'b1, 1'b1, '{40'd64, 1'b0}},
    '{'{1'b0, 21'd1, 40'd0, 7'd0, 64'd0}, 1'b0, 1'b1, '{40'd128, 1'b0}},
    // stride equal to the region wraps at once, always write
    '{'{1'b0, 21'd1, 40'h10_0000, 7'd100, 64'd0}, 1'b1, 1'b1, '{40'h0, 1'b1}},
    // largest region and stride
    '{'{1'b0, 21'd1048576, 40'hFF_FFFF_FFFF, 7'd100, 64'd0}, 1'b1, 1'b1,
      '{40'hFF_FFFF_FFC0, 1'b1}},
    '{'{1'b0, 21'd1048576, 40'hFF_FFFF_FFFF, 7'd100, 64'd0}, 1'b0, 1'b1,
      '{40'h0, 1'b1}},
    // empty region, percent above 100
    '{'{1'b0, 21'd0, 40'd64, 7'd127, 64'd0}, 1'b1, 1'b1, '{40'h0, 1'b1}},
    // oversized region saturates
    '{'{1'b0, 21'h1F_FFFF, 40'hFF_FFFF_FFFF, 7'd0, 64'd0}, 1'b1, 1'b1,
      '{40'hFF_FFFF_FFC0, 1'b0}},
    // stride not line aligned
    '{'{1'b0, 21'd4, 40'd100, 7'd50, 64'd0}, 1'b1, 1'b1, '{40'd64, 1'b1}},
    '{'{1'b0, 21'd4, 40'd100, 7'd50, 64'd0}, 1'b0, 1'b1, '{40'd128, 1'b1}},
    // random mode, empty region still advances the generator; then oversized, full and small regions
    '{'{1'b1, 21'd0, 40'd4096, 7'd100, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 1'b1,
      '{40'h0, 1'b1}},
    '{'{1'b1, 21'h1F_FFFF, 40'd4096, 7'd1, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 1'b0,
      '{40'h0, 1'b0}},
    '{'{1'b1, 21'd1048576, 40'd4096, 7'd99, 64'h0123_4567_89AB_CDEF}, 1'b1, 1'b0,
      '{40'h0, 1'b0}},
    '{'{1'b1, 21'd1048576, 40'd4096, 7'd99, 64'h0123_4567_89AB_CDEF}, 1'b0, 1'b0,
      '{40'h0, 1'b0}},
    '{'{1'b1, 21'd1, 40'd4096, 7'd50, 64'd0}, 1'b0, 1'b0, '{40'h0, 1'b0}},
    '{'{1'b1, 21'd3, 40'd4096, 7'd37, 64'd12345}, 1'b1, 1'b0, '{40'h0, 1'b0}},
    '{'{1'b1, 21'd3, 40'd4096, 7'd37, 64'd12345}, 1'b0, 1'b0, '{40'h0, 1'b0}},
    // back to sequential from a random index
    '{'{1'b0, 21'd1, 40'd1, 7'd100, 64'd12345}, 1'b0, 1'b0, '{40'h0, 1'b0}},
    '{'{1'b0, 21'd1, 40'd1, 7'd100, 64'd12345}, 1'b0, 1'b0, '{40'h0, 1'b0}},
    '{'{1'b0, 21'd2, 40'd64, 7'd50, 64'd12345}, 1'b0, 1'b0, '{40'h0, 1'b0}}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [mapg_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [mapg_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          restart_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [mapg_pkg::AddrOutW-1:0] address_o;
  logic                          is_write_o;

  // Generator model state
  gen_cfg_t         cur_cfg;
  logic [63:0]      lcg_value;
  logic [AddrW-1:0] last_index;

  access_t     pending_accesses[$];
  int unsigned err_count      = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  logic        hold_req        = 1'b0;

  memory_access_pattern_generator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .address_o   (address_o),
    .is_write_o  (is_write_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the model by one access and return what the block should emit
  function automatic access_t next_access(logic restart);
    logic [63:0] region_bytes;
    logic [63:0] idx;
    logic [63:0] step;
    logic [63:0] pct;
    access_t     acc;
    if (restart) begin
      lcg_value  = cur_cfg.seed;
      last_index = '0;
    end
    region_bytes = ((64'(cur_cfg.ws_mb) > MaxRegionMb) ? MaxRegionMb
                                                        : 64'(cur_cfg.ws_mb)) << 20;
    if (cur_cfg.mode == 1'b0) begin
      step = (cur_cfg.stride == '0) ? 64'd64 : 64'(cur_cfg.stride);
      idx  = 64'(last_index) + step;
      if (idx >= region_bytes) idx = '0;
    end else begin
      lcg_value = lcg_value * LcgMult + 64'd1;
      idx = (region_bytes == '0) ? 64'd0 : lcg_value % region_bytes;
    end
    idx[5:0]   = '0;
    last_index = idx[AddrW-1:0];
    pct        = (cur_cfg.pct > 7'd100) ? 64'd100 : 64'(cur_cfg.pct);
    acc.addr   = idx[mapg_pkg::AddrOutW-1:0];
    if (pct == 64'd0) acc.wr = 1'b0;
    else if (pct == 64'd100) acc.wr = 1'b1;
    else acc.wr = (lcg_value % 64'd100) < pct;
    return acc;
  endfunction

  function automatic gen_cfg_t rand_cfg();
    gen_cfg_t    c;
    int unsigned sel;
    c.mode = 1'($urandom);
    sel = $urandom_range(99);
    if (sel < 60) c.ws_mb = 21'($urandom_range(1, 8));
    else if (sel < 70) c.ws_mb = '0;
    else if (sel < 80) c.ws_mb = 21'd1048576;
    else if (sel < 85) c.ws_mb = '1;
    else c.ws_mb = 21'($urandom);
    sel = $urandom_range(99);
    if (sel < 40) c.stride = 40'($urandom_range(1, 64) * 64);
    else if (sel < 55) c.stride = '0;
    else if (sel < 70) c.stride = 40'({$urandom, $urandom});
    else if (sel < 80) c.stride = '1;
    else c.stride = 40'($urandom_range(1, 1 << 22));
    sel = $urandom_range(99);
    if (sel < 15) c.pct = '0;
    else if (sel < 30) c.pct = 7'd100;
    else if (sel < 40) c.pct = 7'($urandom_range(101, 127));
    else c.pct = 7'($urandom_range(1, 99));
    sel = $urandom_range(99);
    if (sel < 10) c.seed = '0;
    else if (sel < 20) c.seed = '1;
    else c.seed = {$urandom, $urandom};
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  // Write all registers back to back; optional junk above each register's width
  task automatic apply_config(input gen_cfg_t c, input logic junk);
    logic [mapg_pkg::CfgIdxW-1:0] regs  [5];
    logic [63:0]                  vals  [5];
    logic [63:0]                  masks [5];
    regs  = '{mapg_pkg::CfgPatternMode, mapg_pkg::CfgWorkingSetMb,
              mapg_pkg::CfgStrideBytes, mapg_pkg::CfgWritePercent,
              mapg_pkg::CfgSeedInit};
    vals  = '{64'(c.mode), 64'(c.ws_mb), 64'(c.stride), 64'(c.pct), c.seed};
    masks = '{64'h1, 64'h1F_FFFF, 64'hFF_FFFF_FFFF, 64'h7F, '1};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i] | (junk ? ({$urandom, $urandom} & ~masks[i]) : 64'd0);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  // Offer one transaction, with a possible random gap first, and log its expectation
  task automatic send_item(input logic restart, input logic use_typed,
                           input access_t typed);
    access_t acc;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    acc = next_access(restart);
    pending_accesses.push_back(use_typed ? typed : acc);
  endtask

  // Stop offering, wait for every outstanding access, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_accesses.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Result side: check accepted accesses, then pick next cycle's stall
  initial begin
    access_t     want;
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_accesses.size() == 0) begin
          report_mismatch("unexpected access", 64'(address_o), 64'd0);
        end else begin
          want = pending_accesses.pop_front();
          if (address_o !== want.addr)
            report_mismatch("address", 64'(address_o), 64'(want.addr));
          if (is_write_o !== want.wr)
            report_mismatch("is_write", 64'(is_write_o), 64'(want.wr));
        end
      end
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Stimulus
  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= mapg_pkg::CfgPatternMode;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    restart_i  <= 1'b0;
    cur_cfg    = ResetCfg;
    lcg_value  = '0;
    last_index = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, no idling
    for (int i = 0; i < NumDirected; i++) begin
      if (DirRows[i].cfg != cur_cfg) begin
        drain();
        apply_config(DirRows[i].cfg, 1'b0);
      end
      send_item(DirRows[i].restart, DirRows[i].has_exp, DirRows[i].exp);
    end

    // random phases, rotating through the idling patterns
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 77;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 77;
        end
        default: begin
          sender_idle_pct = 9;
          recv_stall_pct  = 9;
        end
      endcase
      apply_config(rand_cfg(), ($urandom_range(3) == 0));
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // long output hold while input keeps coming
        if (p == 4 && n == 40) hold_req = 1'b1;
        // sender pause until the block is empty
        if (p == 6 && n == 50) drain();
        send_item(($urandom_range(15) == 0), 1'b0, '0);
      end
    end

    drain();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/mapg_pkg.sv
rtl/memory_access_pattern_generator_core.sv
sim/tb_memory_access_pattern_generator_core.sv
